>>> hw/rtl/hbs_pkg.sv
`default_nettype none

package hbs_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;

    localparam int HEIGHT_W = 24;
    localparam int POS_W    = 32;
    localparam int INV_W    = 24;
    localparam int CELLS_W  = 8;
    localparam int WGT_W    = 16;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;

    // register map, word index
    localparam logic [2:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [2:0] REG_INV_SPACING = 3'd2;
    localparam logic [2:0] REG_CELLS_X     = 3'd3;
    localparam logic [2:0] REG_CELLS_Y     = 3'd4;

    localparam logic [POS_W-1:0]   ORIGIN_RST  = '0;
    localparam logic [INV_W-1:0]   INV_RST     = 24'd256;
    localparam logic [CELLS_W-1:0] CELLS_RST   = 8'd128;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_CLAMP,
        S_RD0,
        S_RD1,
        S_RD2,
        S_RD3,
        S_DX,
        S_PX,
        S_HX,
        S_DY,
        S_PY,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/hbs_ram.sv
`default_nettype none

module hbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/heightmap_bilinear_sampler_unit.sv
// Channel  Direction  Handshake                     Payload
// in       to block   i_in_valid / o_in_ready       i_mode, i_cell_x, i_cell_y, i_height_in,
//                                                   i_pos_x, i_pos_y
// out      from block o_out_valid / i_out_ready     o_height_out
// cfg      to block   psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A load transaction writes its height into the single-port height RAM at the
// accepting edge. A query passes from acceptance to a loaded output register through
// one multiply stage, one clamp stage, four reads from the single-port height RAM,
// then subtract, multiply and add stages for the blends. The input is ready again
// in the cycle after that, and a new query is not taken before then.
// The output register frees the input side: a new transaction is taken while a
// result waits; a query that finishes while the register is full holds in its last
// stage. Reset (synchronous, active low) clears control and configuration only;
// the height RAM is not cleared.

`default_nettype none

module heightmap_bilinear_sampler_unit
    import hbs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_mode,
    input  wire logic [6:0]                 i_cell_x,
    input  wire logic [6:0]                 i_cell_y,
    input  wire logic signed [HEIGHT_W-1:0] i_height_in,
    input  wire logic signed [POS_W-1:0]    i_pos_x,
    input  wire logic signed [POS_W-1:0]    i_pos_y,

    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic signed [HEIGHT_W-1:0]      o_height_out,

    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_AW-1:0]          paddr,
    input  wire logic [APB_DW-1:0]          pwdata,
    output logic      [APB_DW-1:0]          prdata,
    output logic                            pready
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W  = IDX_W + 1;

    function automatic logic [CNT_W-1:0] eff_cells(input logic [CELLS_W-1:0] n,
                                                   input int maxn);
        if (n == '0) begin
            return CNT_W'(1);
        end
        if (int'(n) > maxn) begin
            return CNT_W'(maxn);
        end
        return CNT_W'(n);
    endfunction

    function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [34:0] i,
                                                   input logic [CNT_W-1:0] n);
        logic signed [34:0] top;
        top = $signed(35'(n)) - 35'sd1;
        if (i < 0) begin
            return '0;
        end
        if (i > top) begin
            return IDX_W'(top);
        end
        return IDX_W'(i);
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ADDR_W-1:0] y,
                                                    input logic [ADDR_W-1:0] x);
        return ADDR_W'(y * ADDR_W'(MAX_COLS)) + x;
    endfunction

    // configuration
    logic [POS_W-1:0]   r_origin_x;
    logic [POS_W-1:0]   r_origin_y;
    logic [INV_W-1:0]   r_inv;
    logic [CELLS_W-1:0] r_cells_x;
    logic [CELLS_W-1:0] r_cells_y;
    logic               cfg_wr;

    // control
    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   in_acc;
    logic   out_load;

    // datapath
    logic signed [32:0]         r_dx;
    logic signed [32:0]         r_dy;
    logic signed [33:0]         r_ix;
    logic signed [33:0]         r_iy;
    logic [WGT_W-1:0]           r_wx;
    logic [WGT_W-1:0]           r_wy;
    logic [COL_W-1:0]           r_x0;
    logic [COL_W-1:0]           r_x1;
    logic [ROW_W-1:0]           r_y0;
    logic [ROW_W-1:0]           r_y1;
    logic signed [HEIGHT_W-1:0] r_h00;
    logic signed [HEIGHT_W-1:0] r_h10;
    logic signed [HEIGHT_W:0]   r_d0;
    logic signed [HEIGHT_W:0]   r_d1;
    logic signed [41:0]         r_p0;
    logic signed [41:0]         r_p1;
    logic signed [HEIGHT_W-1:0] r_h0;
    logic signed [HEIGHT_W-1:0] r_h1;
    logic signed [HEIGHT_W:0]   r_dh;
    logic signed [41:0]         r_ph;
    logic signed [HEIGHT_W-1:0] r_height_out;

    logic signed [57:0]         u_x;
    logic signed [57:0]         u_y;
    logic signed [41:0]         p0;
    logic signed [41:0]         p1;
    logic signed [41:0]         ph;
    logic signed [25:0]         s0;
    logic signed [25:0]         s1;
    logic signed [25:0]         sh;
    logic [CNT_W-1:0]           eff_x;
    logic [CNT_W-1:0]           eff_y;

    // RAM port
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_addr;
    logic signed [HEIGHT_W-1:0] ram_rdata;
    logic                       load_ok;

    hbs_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_height_in),
        .o_rdata (ram_rdata)
    );

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        case (paddr[4:2])
            REG_ORIGIN_X:    prdata = r_origin_x;
            REG_ORIGIN_Y:    prdata = r_origin_y;
            REG_INV_SPACING: prdata = APB_DW'(r_inv);
            REG_CELLS_X:     prdata = APB_DW'(r_cells_x);
            REG_CELLS_Y:     prdata = APB_DW'(r_cells_y);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= ORIGIN_RST;
            r_origin_y <= ORIGIN_RST;
            r_inv      <= INV_RST;
            r_cells_x  <= CELLS_RST;
            r_cells_y  <= CELLS_RST;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_ORIGIN_X:    r_origin_x <= pwdata;
                REG_ORIGIN_Y:    r_origin_y <= pwdata;
                REG_INV_SPACING: r_inv      <= pwdata[INV_W-1:0];
                REG_CELLS_X:     r_cells_x  <= pwdata[CELLS_W-1:0];
                REG_CELLS_Y:     r_cells_y  <= pwdata[CELLS_W-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- sequencer ----------------
    assign in_acc   = i_in_valid & o_in_ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && i_mode == MODE_QUERY) n_state = S_MUL;
            S_MUL:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_RD0;
            S_RD0:   n_state = S_RD1;
            S_RD1:   n_state = S_RD2;
            S_RD2:   n_state = S_RD3;
            S_RD3:   n_state = S_DX;
            S_DX:    n_state = S_PX;
            S_PX:    n_state = S_HX;
            S_HX:    n_state = S_DY;
            S_DY:    n_state = S_PY;
            S_PY:    n_state = S_OUT;
            S_OUT:   if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign load_ok = (int'(i_cell_x) < MAX_COLS) && (int'(i_cell_y) < MAX_ROWS);

    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_addr   = cell_addr(ADDR_W'(i_cell_y), ADDR_W'(i_cell_x));
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                ram_we     = i_in_valid && (i_mode == MODE_LOAD) && load_ok;
            end
            S_RD0:   ram_addr = cell_addr(ADDR_W'(r_y0), ADDR_W'(r_x0));
            S_RD1:   ram_addr = cell_addr(ADDR_W'(r_y0), ADDR_W'(r_x1));
            S_RD2:   ram_addr = cell_addr(ADDR_W'(r_y1), ADDR_W'(r_x0));
            S_RD3:   ram_addr = cell_addr(ADDR_W'(r_y1), ADDR_W'(r_x1));
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // ---------------- datapath ----------------
    assign u_x   = r_dx * $signed({1'b0, r_inv});
    assign u_y   = r_dy * $signed({1'b0, r_inv});
    assign eff_x = eff_cells(r_cells_x, MAX_COLS);
    assign eff_y = eff_cells(r_cells_y, MAX_ROWS);
    assign p0    = r_d0 * $signed({1'b0, r_wx});
    assign p1    = r_d1 * $signed({1'b0, r_wx});
    assign ph    = r_dh * $signed({1'b0, r_wy});
    assign s0    = $signed({{2{r_h00[HEIGHT_W-1]}}, r_h00}) + $signed(r_p0[41:16]);
    assign s1    = $signed({{2{r_h10[HEIGHT_W-1]}}, r_h10}) + $signed(r_p1[41:16]);
    assign sh    = $signed({{2{r_h0[HEIGHT_W-1]}}, r_h0}) + $signed(r_ph[41:16]);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dx <= $signed({i_pos_x[POS_W-1], i_pos_x})
                      - $signed({r_origin_x[POS_W-1], r_origin_x});
                r_dy <= $signed({i_pos_y[POS_W-1], i_pos_y})
                      - $signed({r_origin_y[POS_W-1], r_origin_y});
            end
            S_MUL: begin
                r_ix <= u_x[57:24];
                r_iy <= u_y[57:24];
                r_wx <= u_x[23:8];
                r_wy <= u_y[23:8];
            end
            S_CLAMP: begin
                r_x0 <= COL_W'(clamp_idx($signed({r_ix[33], r_ix}), eff_x));
                r_x1 <= COL_W'(clamp_idx($signed({r_ix[33], r_ix}) + 35'sd1, eff_x));
                r_y0 <= ROW_W'(clamp_idx($signed({r_iy[33], r_iy}), eff_y));
                r_y1 <= ROW_W'(clamp_idx($signed({r_iy[33], r_iy}) + 35'sd1, eff_y));
            end
            // read data arrives in the cycle after its address
            S_RD1: r_h00 <= ram_rdata;
            S_RD2: r_d0  <= $signed({ram_rdata[HEIGHT_W-1], ram_rdata})
                          - $signed({r_h00[HEIGHT_W-1], r_h00});
            S_RD3: r_h10 <= ram_rdata;
            S_DX:  r_d1  <= $signed({ram_rdata[HEIGHT_W-1], ram_rdata})
                          - $signed({r_h10[HEIGHT_W-1], r_h10});
            S_PX: begin
                r_p0 <= p0;
                r_p1 <= p1;
            end
            S_HX: begin
                r_h0 <= s0[HEIGHT_W-1:0];
                r_h1 <= s1[HEIGHT_W-1:0];
            end
            S_DY:  r_dh <= $signed({r_h1[HEIGHT_W-1], r_h1})
                         - $signed({r_h0[HEIGHT_W-1], r_h0});
            S_PY:  r_ph <= ph;
            S_OUT: if (out_load) r_height_out <= sh[HEIGHT_W-1:0];
            default: ;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_height_out = r_height_out;

endmodule

`default_nettype wire
